// ===== hdl/segx_pkg.sv =====
// Shared constants and types of the segment intersection block.
package segx_pkg;

  // Field and datapath widths.
  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DET_W    = PROD_W + 1;
  localparam int CROSS_W  = 2 * COORD_W + 1;
  localparam int NUM_W    = CROSS_W + DIFF_W + 1;
  localparam int HALF_W   = 32;
  localparam int THR_W    = 41;
  localparam int Q_W      = COORD_W;

  // Default number of fraction bits in a coordinate.
  localparam int COORD_FRAC_BITS = 23;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // One classified word handed from front to back.
  typedef struct packed {
    logic                    hit;
    logic signed [DET_W-1:0] delta;
    logic signed [NUM_W-1:0] d1;
    logic signed [NUM_W-1:0] d2;
  } si_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } si_qstat_t;

endpackage

// ===== hdl/segx_front.sv =====
// Front part: accepts segment pairs, forms determinants and classifies them.
module segx_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [segx_pkg::COORD_W-1:0] a_start_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] a_start_lat_i,
  input  logic signed [segx_pkg::COORD_W-1:0] a_end_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] a_end_lat_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_start_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_start_lat_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_end_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_end_lat_i,
  input  logic        [segx_pkg::THR_W-1:0]   thr_i,
  input  segx_pkg::si_qstat_t                 qstat_i,
  output logic                              push_o,
  output segx_pkg::si_entry_t                 entry_o
);
  import segx_pkg::*;

  logic en;
  logic [4:0] v_q;

  // Stage 1: coordinate differences.
  logic signed [DIFF_W-1:0] dx21_q, dy34_q, dx34_q, dy21_q, dx31_q, dy31_q, dx43_q, dy12_q;
  logic signed [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  // Stage 2: products.
  logic signed [PROD_W-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [2*COORD_W-1:0] p7_q, p8_q, p9_q, p10_q;
  logic signed [DIFF_W-1:0] dx21b_q, dx43b_q, dy34b_q, dy12b_q;
  // Stage 3: determinants.
  logic signed [DET_W-1:0] delta_q, nl_q, nm_q;
  logic signed [CROSS_W-1:0] ca_q, cb_q;
  logic signed [DIFF_W-1:0] dx21c_q, dx43c_q, dy34c_q, dy12c_q;
  // Stage 4: classification and split partial products.
  logic signed [DET_W-1:0] delta4_q;
  logic hit4_q;
  logic signed [PROD_W-1:0] c1h_q, c1l_q, a1h_q, a1l_q, a2h_q, a2l_q, c2h_q, c2l_q;
  // Stage 5: Cramer numerators.
  logic signed [DET_W-1:0] delta5_q;
  logic hit5_q;
  logic signed [NUM_W-1:0] d1_q, d2_q;

  // The pipeline moves unless its last word cannot enter a full queue.
  assign en         = !v_q[4] || !qstat_i.full;
  assign in_stall_o = !en;
  assign push_o     = v_q[4] && en;
  assign entry_o    = '{hit: hit5_q, delta: delta5_q, d1: d1_q, d2: d2_q};

  // Valid bits of the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  // Classification of the determinant and the two parameter numerators.
  logic signed [DET_W:0] dd, nnl, nnm;
  logic hit4_d;
  always_comb begin
    dd  = delta_q[DET_W-1] ? -(DET_W+1)'(delta_q) : (DET_W+1)'(delta_q);
    nnl = delta_q[DET_W-1] ? -(DET_W+1)'(nl_q) : (DET_W+1)'(nl_q);
    nnm = delta_q[DET_W-1] ? -(DET_W+1)'(nm_q) : (DET_W+1)'(nm_q);
    hit4_d = (dd > $signed({{(DET_W+1-THR_W){1'b0}}, thr_i}))
           && !nnl[DET_W] && (nnl <= dd) && !nnm[DET_W] && (nnm <= dd);
  end

  // Datapath registers; each stage loads when the pipeline moves.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx21_q <= DIFF_W'(a_end_lon_i) - DIFF_W'(a_start_lon_i);
      dy34_q <= DIFF_W'(b_start_lat_i) - DIFF_W'(b_end_lat_i);
      dx34_q <= DIFF_W'(b_start_lon_i) - DIFF_W'(b_end_lon_i);
      dy21_q <= DIFF_W'(a_end_lat_i) - DIFF_W'(a_start_lat_i);
      dx31_q <= DIFF_W'(b_start_lon_i) - DIFF_W'(a_start_lon_i);
      dy31_q <= DIFF_W'(b_start_lat_i) - DIFF_W'(a_start_lat_i);
      dx43_q <= DIFF_W'(b_end_lon_i) - DIFF_W'(b_start_lon_i);
      dy12_q <= DIFF_W'(a_start_lat_i) - DIFF_W'(a_end_lat_i);
      x1_q <= a_start_lon_i;
      y1_q <= a_start_lat_i;
      x2_q <= a_end_lon_i;
      y2_q <= a_end_lat_i;
      x3_q <= b_start_lon_i;
      y3_q <= b_start_lat_i;
      x4_q <= b_end_lon_i;
      y4_q <= b_end_lat_i;

      p1_q  <= dx21_q * dy34_q;
      p2_q  <= dx34_q * dy21_q;
      p3_q  <= dx31_q * dy34_q;
      p4_q  <= dx34_q * dy31_q;
      p5_q  <= dx21_q * dy31_q;
      p6_q  <= dx31_q * dy21_q;
      p7_q  <= y1_q * x2_q;
      p8_q  <= x1_q * y2_q;
      p9_q  <= y3_q * x4_q;
      p10_q <= x3_q * y4_q;
      dx21b_q <= dx21_q;
      dx43b_q <= dx43_q;
      dy34b_q <= dy34_q;
      dy12b_q <= dy12_q;

      delta_q <= DET_W'(p1_q) - DET_W'(p2_q);
      nl_q    <= DET_W'(p3_q) - DET_W'(p4_q);
      nm_q    <= DET_W'(p5_q) - DET_W'(p6_q);
      ca_q    <= CROSS_W'(p7_q) - CROSS_W'(p8_q);
      cb_q    <= CROSS_W'(p9_q) - CROSS_W'(p10_q);
      dx21c_q <= dx21b_q;
      dx43c_q <= dx43b_q;
      dy34c_q <= dy34b_q;
      dy12c_q <= dy12b_q;

      // Wide products are split into a signed high half and an unsigned low half.
      delta4_q <= delta_q;
      hit4_q   <= hit4_d;
      c1h_q <= $signed(cb_q[CROSS_W-1:HALF_W]) * dx21c_q;
      c1l_q <= $signed({1'b0, cb_q[HALF_W-1:0]}) * dx21c_q;
      a1h_q <= $signed(ca_q[CROSS_W-1:HALF_W]) * dx43c_q;
      a1l_q <= $signed({1'b0, ca_q[HALF_W-1:0]}) * dx43c_q;
      a2h_q <= $signed(ca_q[CROSS_W-1:HALF_W]) * dy34c_q;
      a2l_q <= $signed({1'b0, ca_q[HALF_W-1:0]}) * dy34c_q;
      c2h_q <= $signed(cb_q[CROSS_W-1:HALF_W]) * dy12c_q;
      c2l_q <= $signed({1'b0, cb_q[HALF_W-1:0]}) * dy12c_q;

      delta5_q <= delta4_q;
      hit5_q   <= hit4_q;
      d1_q <= (NUM_W'(c1h_q) <<< HALF_W) + NUM_W'(c1l_q)
            - (NUM_W'(a1h_q) <<< HALF_W) - NUM_W'(a1l_q);
      d2_q <= (NUM_W'(a2h_q) <<< HALF_W) + NUM_W'(a2l_q)
            - (NUM_W'(c2h_q) <<< HALF_W) - NUM_W'(c2l_q);
    end
  end

endmodule

// ===== hdl/segx_queue.sv =====
// Short queue of classified words between the front and the back.
module segx_queue #(
  parameter int Depth = segx_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  segx_pkg::si_entry_t  entry_i,
  input  logic                 pop_i,
  output segx_pkg::si_entry_t  entry_o,
  output segx_pkg::si_qstat_t  qstat_o
);
  import segx_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  si_entry_t         slot_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign qstat_o.full  = (cnt_q == (PtrW+1)'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign entry_o       = slot_q[rd_q];

  // Pointers wrap at the depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  // Storage of the words.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!qstat_o.full || pop_i))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count beyond its depth");

endmodule

// ===== hdl/segx_back.sv =====
// Back part: divides the Cramer numerators by the determinant and rounds.
module segx_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  segx_pkg::si_entry_t                 entry_i,
  input  segx_pkg::si_qstat_t                 qstat_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic signed [segx_pkg::COORD_W-1:0] cross_lon_o,
  output logic signed [segx_pkg::COORD_W-1:0] cross_lat_o
);
  import segx_pkg::*;

  localparam int Stages = Q_W;

  logic en;
  logic                v_q    [Stages+1];
  logic                hit_q  [Stages+1];
  logic                neg1_q [Stages+1];
  logic                neg2_q [Stages+1];
  logic [DET_W-1:0]    ad_q   [Stages+1];
  logic [NUM_W-1:0]    r1_q   [Stages+1];
  logic [NUM_W-1:0]    r2_q   [Stages+1];
  logic [Q_W-1:0]      q1_q   [Stages+1];
  logic [Q_W-1:0]      q2_q   [Stages+1];

  logic                out_v_q, out_hit_q;
  logic [Q_W-1:0]      out_lon_q, out_lat_q;

  // The whole back pipeline moves unless the result word is held.
  assign en          = !out_v_q || !out_stall_i;
  assign pop_o       = en && !qstat_i.empty;
  assign out_valid_o = out_v_q;
  assign hit_o       = out_hit_q;
  assign cross_lon_o = out_lon_q;
  assign cross_lat_o = out_lat_q;

  // Quotient rounded to nearest, ties away from zero, then saturated and signed.
  function automatic logic [Q_W-1:0] round_sat(input logic [NUM_W-1:0] r,
                                                input logic [Q_W-1:0]   q,
                                                input logic [DET_W-1:0] ad,
                                                input logic             neg);
    logic           up;
    logic [Q_W:0]   qr, lim, mag;
    up  = ({r, 1'b0} >= (NUM_W+1)'(ad));
    qr  = {1'b0, q} + {{Q_W{1'b0}}, up};
    lim = neg ? ((Q_W+1)'(1) << (Q_W - 1)) : (((Q_W+1)'(1) << (Q_W - 1)) - 1'b1);
    mag = (qr > lim) ? lim : qr;
    return neg ? Q_W'(-mag) : mag[Q_W-1:0];
  endfunction

  // Entry stage: magnitudes and signs of the operands.
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q[0]  <= entry_i.hit;
      neg1_q[0] <= entry_i.d1[NUM_W-1] ^ entry_i.delta[DET_W-1];
      neg2_q[0] <= entry_i.d2[NUM_W-1] ^ entry_i.delta[DET_W-1];
      ad_q[0]   <= entry_i.delta[DET_W-1] ? DET_W'(-entry_i.delta) : DET_W'(entry_i.delta);
      r1_q[0]   <= entry_i.d1[NUM_W-1] ? NUM_W'(-entry_i.d1) : NUM_W'(entry_i.d1);
      r2_q[0]   <= entry_i.d2[NUM_W-1] ? NUM_W'(-entry_i.d2) : NUM_W'(entry_i.d2);
      q1_q[0]   <= '0;
      q2_q[0]   <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < Stages; k++) begin : g_div
    localparam int Sh = Stages - 1 - k;
    logic [NUM_W-1:0] dsh;
    logic             t1, t2;
    assign dsh = NUM_W'(ad_q[k]) << Sh;
    assign t1  = (r1_q[k] >= dsh);
    assign t2  = (r2_q[k] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en) begin
        hit_q[k+1]  <= hit_q[k];
        neg1_q[k+1] <= neg1_q[k];
        neg2_q[k+1] <= neg2_q[k];
        ad_q[k+1]   <= ad_q[k];
        r1_q[k+1]   <= t1 ? r1_q[k] - dsh : r1_q[k];
        r2_q[k+1]   <= t2 ? r2_q[k] - dsh : r2_q[k];
        q1_q[k+1]   <= {q1_q[k][Q_W-2:0], t1};
        q2_q[k+1]   <= {q2_q[k][Q_W-2:0], t2};
      end
    end
  end

  // Valid bits of the back pipeline and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Stages; i++) begin
        v_q[i] <= 1'b0;
      end
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= !qstat_i.empty;
      for (int i = 0; i < Stages; i++) begin
        v_q[i+1] <= v_q[i];
      end
      out_v_q <= v_q[Stages];
    end
  end

  // Result word: rounded point on a hit, zeros otherwise.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= hit_q[Stages];
      out_lon_q <= hit_q[Stages]
        ? round_sat(r1_q[Stages], q1_q[Stages], ad_q[Stages], neg1_q[Stages]) : '0;
      out_lat_q <= hit_q[Stages]
        ? round_sat(r2_q[Stages], q2_q[Stages], ad_q[Stages], neg2_q[Stages]) : '0;
    end
  end

endmodule

// ===== hdl/segment_intersection.sv =====
// Top level of the segment intersection block: threshold register and the three parts.
// Takes one pair of segments per cycle unless in_stall_o is raised and delivers one
// result word per pair, in order. A word passes the front stages (differences,
// products, determinants, parallel and parameter tests with split partial products,
// Cramer numerators), then a four-word queue and the back, whose 32-stage restoring
// divider pipeline computes one quotient bit per stage for both coordinates. The
// threshold register is written through the configuration channel, which is always
// ready, and must only be changed while the block is empty.
module segment_intersection #(
  parameter int CoordFracBits = segx_pkg::COORD_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [segx_pkg::THR_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [segx_pkg::COORD_W-1:0] a_start_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] a_start_lat_i,
  input  logic signed [segx_pkg::COORD_W-1:0] a_end_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] a_end_lat_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_start_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_start_lat_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_end_lon_i,
  input  logic signed [segx_pkg::COORD_W-1:0] b_end_lat_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic signed [segx_pkg::COORD_W-1:0] cross_lon_o,
  output logic signed [segx_pkg::COORD_W-1:0] cross_lat_o
);
  import segx_pkg::*;

  // Reset threshold is 1e-7 square degrees in the coordinate format.
  localparam logic [63:0] ThrFull  = (64'd1 << (2 * CoordFracBits)) / 64'd10000000;
  localparam logic [THR_W-1:0] ThrReset = ThrFull[THR_W-1:0];

  logic [THR_W-1:0] thr_q;
  logic             push, pop;
  si_entry_t        push_entry, pop_entry;
  si_qstat_t        qstat;

  assign cfg_ready_o = 1'b1;

  // Parallel threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  segx_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .a_start_lon_i, .a_start_lat_i, .a_end_lon_i, .a_end_lat_i,
    .b_start_lon_i, .b_start_lat_i, .b_end_lon_i, .b_end_lat_i,
    .thr_i   (thr_q),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  segx_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .qstat_o (qstat)
  );

  segx_back u_back (
    .clk_i, .rst_ni,
    .entry_i (pop_entry),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i, .hit_o, .cross_lon_o, .cross_lat_o
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the segment intersection block.
`timescale 1ns / 100ps

module tb_top;
  import segx_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [7:0][COORD_W-1:0] c;
  } seg_pair_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] lon;
    logic [COORD_W-1:0] lat;
  } crossing_t;

  localparam logic [THR_W-1:0] THR_RESET = 41'd7036874;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;
  logic cfg_ready_o;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [7:0][COORD_W-1:0] coords = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic hit_o;
  logic signed [COORD_W-1:0] cross_lon_o, cross_lat_o;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  logic [THR_W-1:0] thr_model = THR_RESET;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int failures = 0;
  int quiet_cycles = 0;
  bit in_taken = 1'b0;

  // Clock.
  always #5 clk_i = ~clk_i;

  segment_intersection DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .a_start_lon_i (coords[0]),
    .a_start_lat_i (coords[1]),
    .a_end_lon_i   (coords[2]),
    .a_end_lat_i   (coords[3]),
    .b_start_lon_i (coords[4]),
    .b_start_lat_i (coords[5]),
    .b_end_lon_i   (coords[6]),
    .b_end_lat_i   (coords[7]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .hit_o         (hit_o),
    .cross_lon_o   (cross_lon_o),
    .cross_lat_o   (cross_lat_o)
  );

  function automatic wide_t widen(logic [COORD_W-1:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // True when 0 <= n/d <= 1, for nonzero d.
  function automatic bit param_in_unit(wide_t n, wide_t d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    return (n >= 0) && (n <= d);
  endfunction

  // Quotient rounded to nearest, ties away from zero, saturated to 32 bits.
  function automatic logic [COORD_W-1:0] round_quotient(wide_t n, wide_t d);
    logic [127:0] an, ad, q, r;
    logic [127:0] lim;
    logic [COORD_W-1:0] mag;
    bit neg;
    neg = (n < 0) != (d < 0);
    an = wabs(n);
    ad = wabs(d);
    q = an / ad;
    r = an % ad;
    if ((r << 1) >= ad) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    mag = (q > lim) ? lim[COORD_W-1:0] : q[COORD_W-1:0];
    return neg ? -mag : mag;
  endfunction

  // Crossing test and Cramer point of one pair under the current threshold.
  function automatic crossing_t predict_crossing(seg_pair_t p, logic [THR_W-1:0] thr);
    wide_t x1, y1, x2, y2, x3, y3, x4, y4;
    wide_t delta, nl, nm, ca, cb, d1, d2;
    crossing_t res;
    x1 = widen(p.c[0]); y1 = widen(p.c[1]); x2 = widen(p.c[2]); y2 = widen(p.c[3]);
    x3 = widen(p.c[4]); y3 = widen(p.c[5]); x4 = widen(p.c[6]); y4 = widen(p.c[7]);
    res = '0;
    delta = (x2 - x1) * (y3 - y4) - (x3 - x4) * (y2 - y1);
    if (wabs(delta) <= $signed({87'd0, thr})) return res;
    nl = (x3 - x1) * (y3 - y4) - (x3 - x4) * (y3 - y1);
    if (!param_in_unit(nl, delta)) return res;
    nm = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
    if (!param_in_unit(nm, delta)) return res;
    ca = y1 * x2 - x1 * y2;
    cb = y3 * x4 - x3 * y4;
    d1 = cb * (x2 - x1) - ca * (x4 - x3);
    d2 = ca * (y3 - y4) - cb * (y1 - y2);
    res.hit = 1'b1;
    res.lon = round_quotient(d1, delta);
    res.lat = round_quotient(d2, delta);
    return res;
  endfunction

  // Sampling at the rising edge: accepted pairs become expectations, results are checked.
  always @(posedge clk_i) begin
    crossing_t exp_c;
    bit moved;
    moved = 1'b0;
    in_taken = in_valid && !in_stall_o;
    if (in_taken) begin
      expected_crossings.push_back(predict_crossing(seg_pair_t'(coords), thr_model));
      moved = 1'b1;
    end
    if (cfg_valid && cfg_ready_o) moved = 1'b1;
    if (rst_ni && out_valid_o && !out_stall) begin
      moved = 1'b1;
      if (expected_crossings.size() == 0) begin
        $error("result word with no expectation waiting");
        failures++;
      end else begin
        exp_c = expected_crossings.pop_front();
        if (hit_o !== exp_c.hit) begin
          $error("hit: expected %0d, got %0d", exp_c.hit, hit_o);
          failures++;
        end
        if (cross_lon_o !== exp_c.lon) begin
          $error("cross_lon: expected %0d, got %0d", $signed(exp_c.lon), cross_lon_o);
          failures++;
        end
        if (cross_lat_o !== exp_c.lat) begin
          $error("cross_lat: expected %0d, got %0d", $signed(exp_c.lat), cross_lat_o);
          failures++;
        end
      end
    end
    // Watchdog on cycles in which nothing is accepted on any channel.
    if (moved)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: offers pending pairs at the falling edge, holding a stalled word.
  always @(negedge clk_i) begin
    bit offer;
    if (in_valid && in_taken) void'(pending_pairs.pop_front());
    if (in_valid && !in_taken) begin
      offer = 1'b1;
    end else begin
      offer = rst_ni && pending_pairs.size() > 0 &&
              ($urandom_range(99) >= send_idle_pct);
      in_valid <= offer;
      if (offer) coords <= pending_pairs[0].c;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left == 0 && holds_served < hold_requests) begin
      holds_served++;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [COORD_W-1:0] srand(int lim);
    return COORD_W'($signed($urandom_range(2 * lim)) - lim);
  endfunction

  task automatic add_pair(logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                          logic [COORD_W-1:0] x2, logic [COORD_W-1:0] y2,
                          logic [COORD_W-1:0] x3, logic [COORD_W-1:0] y3,
                          logic [COORD_W-1:0] x4, logic [COORD_W-1:0] y4);
    seg_pair_t p;
    p.c = {y4, x4, y3, x3, y2, x2, y1, x1};
    pending_pairs.push_back(p);
  endtask

  // Random pairs: half of them crossing or touching by construction, the rest noise and parallels.
  task automatic add_random_pairs(int n);
    logic [COORD_W-1:0] px, py, ax, ay, bx, by, ox, oy;
    for (int i = 0; i < n; i++) begin
      px = srand(1 << 28); py = srand(1 << 28);
      ax = srand(1 << 20); ay = srand(1 << 20);
      bx = srand(1 << 20); by = srand(1 << 20);
      ox = srand(1 << 12); oy = srand(1 << 12);
      case ($urandom_range(9))
        0, 1: add_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        2, 3: add_pair(srand(255), srand(255), srand(255), srand(255),
                       srand(255), srand(255), srand(255), srand(255));
        4: add_pair(px, py, px + ax, py + ay, px + ox, py + oy, px + ox + ax, py + oy + ay);
        5: add_pair(px, py, px + ax, py + ay, px + ax, py + ay, px + bx, py + by);
        default: add_pair(px - ax, py - ay, px + ax + ox, py + ay, px - bx, py - by + oy,
                          px + bx, py + by);
      endcase
    end
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    thr_model = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_pairs.size() == 0 && !in_valid && expected_crossings.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  localparam logic [COORD_W-1:0] ONE  = 32'h0080_0000;
  localparam logic [COORD_W-1:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] MINC = 32'h8000_0000;

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs under the reset threshold.
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
    add_pair(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC);
    add_pair(0, 0, ONE, ONE, 0, ONE, ONE, 0);
    add_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
    add_pair(MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MINC);
    add_pair(0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE);
    add_pair(0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 0);
    add_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE);
    add_pair(0, 0, ONE, 0, ONE / 2, 0, 2 * ONE, 0);
    add_pair(0, 0, ONE, ONE, 2 * ONE, 0, 3 * ONE, -ONE);
    add_pair(0, 0, ONE, ONE, ONE + 1, ONE + 1, 2 * ONE, 0);
    add_pair(0, 0, ONE, 0, 0, 0, 1, 1);
    add_pair(0, 0, ONE, 0, 5, -1, 5, 1);
    add_pair(0, 0, 0, 0, 0, -ONE, 0, ONE);
    add_pair(0, 0, ONE, 3, 0, 1, ONE, 0);
    add_pair(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
    add_pair(-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE);
    add_random_pairs(190);
    wait_drained();

    // Threshold zero, sender idling.
    write_threshold('0);
    send_idle_pct = 83;
    add_random_pairs(210);
    wait_drained();

    // Threshold of 2^40, receiver stalling.
    write_threshold(41'h100_0000_0000);
    send_idle_pct = 0;
    stall_pct = 83;
    add_random_pairs(210);
    wait_drained();

    // Random threshold, both sides idling.
    write_threshold(THR_W'({$urandom, $urandom} % 64'h100_0000_0001));
    send_idle_pct = 33;
    stall_pct = 33;
    add_random_pairs(210);
    wait_drained();

    // Reset threshold again with a long hold-off at the output.
    write_threshold(THR_RESET);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    add_random_pairs(210);
    wait_drained();

    // Small threshold, sender idling.
    write_threshold(41'($urandom_range(1000)));
    send_idle_pct = 33;
    stall_pct = 0;
    add_random_pairs(210);
    wait_drained();

    repeat (100) @(posedge clk_i);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/segx_pkg.sv
hdl/segx_front.sv
hdl/segx_queue.sv
hdl/segx_back.sv
hdl/segment_intersection.sv
tb/tb_top.sv
